>>> rtl/multi_channel_tick_timer_bank_assert.svh
// Assertion macros for the tick timer bank checks.
`ifndef MULTI_CHANNEL_TICK_TIMER_BANK_ASSERT_SVH
`define MULTI_CHANNEL_TICK_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS
`define MCTT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("timer bank check failed");
`define MCTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("timer bank check failed");
`else
`define MCTT_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define MCTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/mctt_pkg.sv
// Shared constants and types for the tick timer bank.
package mctt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int STEP_W     = $clog2(NUM_TIMERS + 1);
    localparam int CNT_W      = 32;
    localparam int FIRE_W     = 16;
    localparam int HND_W      = 16;
    localparam int ID_W       = 8;
    localparam int REQ_W      = 3;
    localparam int ENTRY_W    = 2 * CNT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 3'd0,
        REQ_SET   = 3'd1,
        REQ_START = 3'd2,
        REQ_STOP  = 3'd3,
        REQ_RESET = 3'd4,
        REQ_ALLOC = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_SWEEP,
        S_DONE
    } t_state;

endpackage

>>> rtl/mctt_ram.sv
// Generic simple dual-port RAM with registered read data.
module mctt_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [ADDR_W-1:0]        i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word; read data is valid in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/multi_channel_tick_timer_bank.sv
// Top level of the tick timer bank: request sequencer around the timer RAM.
//
// Requests enter on the slave stream (kind in tuser, operands in tdata) and
// every request returns exactly one beat on the master stream carrying the
// fire mask, the tick counter after the request and the allocated handle.
// Counts and reload values live in one RAM word per timer; enable and mode
// bits sit in flip-flops. Requests are handled one at a time.
// A tick sweeps the RAM one timer per cycle, read then write back, and then
// hands its result to the output. Set, start, stop, reset and allocate
// pass through read, modify and output states (S_READ, S_WRITE, S_DONE).
// The output register frees the input side: a new request is taken while the
// previous result waits. When the receiver stalls, the finished result of the
// next request holds in the sequencer until the output register drains.
// Reset clears the tick counter, handle counter, enables, modes and the
// per-entry valid bits, so every timer reads as zero until written; no
// clearing pass is needed and requests are taken right after reset.
`include "multi_channel_tick_timer_bank_assert.svh"

module multi_channel_tick_timer_bank
    import mctt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // timer_id[7:0], period[39:8], periodic[40], zero fill
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // fire_mask[15:0], tick_count[47:16], handle[63:48]
);

    t_state                r_state, n_state;
    t_req                  r_req;
    logic [ID_W-1:0]       r_id;
    logic [CNT_W-1:0]      r_period;
    logic                  r_periodic;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [FIRE_W-1:0]     r_mask, n_mask;
    logic [CNT_W-1:0]      r_ticks, n_ticks;
    logic [HND_W-1:0]      r_handles, n_handles;
    logic [HND_W-1:0]      r_hnd, n_hnd;
    logic [NUM_TIMERS-1:0] r_en, n_en;
    logic [NUM_TIMERS-1:0] r_rep, n_rep;
    logic [NUM_TIMERS-1:0] r_vld, n_vld;
    logic                  r_out_valid;
    logic [FIRE_W-1:0]     r_out_mask;
    logic [CNT_W-1:0]      r_out_ticks;
    logic [HND_W-1:0]      r_out_hnd;

    logic                  s_acc;
    logic                  out_free;
    logic                  load_out;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic                  id_ok;
    logic [IDX_W-1:0]      id_idx;
    logic [IDX_W-1:0]      sw_idx;
    logic [IDX_W-1:0]      ent_idx;
    logic [CNT_W-1:0]      ent_cnt;
    logic [CNT_W-1:0]      ent_rld;
    logic [CNT_W-1:0]      dec_cnt;

    mctt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // Decode the addressed timer and the entry under work
    assign id_ok   = (r_id < ID_W'(NUM_TIMERS));
    assign id_idx  = r_id[IDX_W-1:0];
    assign sw_idx  = IDX_W'(r_step - STEP_W'(1));
    assign ent_idx = (r_state == S_SWEEP) ? sw_idx : id_idx;
    assign ent_cnt = r_vld[ent_idx] ? ram_rdata[CNT_W-1:0] : '0;
    assign ent_rld = r_vld[ent_idx] ? ram_rdata[ENTRY_W-1:CNT_W] : '0;
    assign dec_cnt = ent_cnt - CNT_W'(1);

    // Sequence one request: read, modify, write back, then hand to output
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_mask    = r_mask;
        n_ticks   = r_ticks;
        n_handles = r_handles;
        n_hnd     = r_hnd;
        n_en      = r_en;
        n_rep     = r_rep;
        n_vld     = r_vld;
        ram_we    = 1'b0;
        ram_waddr = ent_idx;
        ram_wdata = {ent_rld, ent_rld};
        ram_raddr = id_idx;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_mask = '0;
                    n_hnd  = '0;
                    n_step = '0;
                    if (t_req'(i_s_tuser) == REQ_TICK) begin
                        n_ticks = r_ticks + CNT_W'(1);
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_DONE;
                case (r_req)
                    REQ_SET: begin
                        if (id_ok) begin
                            ram_we        = 1'b1;
                            ram_wdata     = {r_period, r_period};
                            n_rep[id_idx] = r_periodic;
                            n_vld[id_idx] = 1'b1;
                        end
                    end
                    REQ_START: begin
                        if (id_ok) begin
                            ram_we        = 1'b1;
                            n_en[id_idx]  = 1'b1;
                            n_vld[id_idx] = 1'b1;
                        end
                    end
                    REQ_STOP: begin
                        if (id_ok) begin
                            n_en[id_idx] = 1'b0;
                        end
                    end
                    REQ_RESET: begin
                        if (id_ok) begin
                            ram_we        = 1'b1;
                            n_en[id_idx]  = 1'b0;
                            n_vld[id_idx] = 1'b1;
                        end
                    end
                    REQ_ALLOC: begin
                        n_hnd     = r_handles;
                        n_handles = r_handles + HND_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
            S_SWEEP: begin
                // Issue the read for this step, process the entry read last step
                ram_raddr = r_step[IDX_W-1:0];
                n_step    = r_step + STEP_W'(1);
                if (r_step != '0 && HND_W'(sw_idx) < r_handles && r_en[sw_idx]) begin
                    ram_we        = 1'b1;
                    n_vld[sw_idx] = 1'b1;
                    if (dec_cnt == '0) begin
                        n_mask = r_mask | (FIRE_W'(1) << sw_idx);
                        if (!r_rep[sw_idx]) begin
                            n_en[sw_idx] = 1'b0;
                        end
                    end else begin
                        ram_wdata = {ent_rld, dec_cnt};
                    end
                end
                if (r_step == STEP_W'(NUM_TIMERS)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ticks   <= '0;
            r_handles <= '0;
            r_en      <= '0;
            r_rep     <= '0;
            r_vld     <= '0;
        end else begin
            r_state   <= n_state;
            r_ticks   <= n_ticks;
            r_handles <= n_handles;
            r_en      <= n_en;
            r_rep     <= n_rep;
            r_vld     <= n_vld;
        end
    end

    // Capture the request and per-request working values
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_req      <= t_req'(i_s_tuser);
            r_id       <= i_s_tdata[7:0];
            r_period   <= i_s_tdata[39:8];
            r_periodic <= i_s_tdata[40];
        end
        r_step <= n_step;
        r_mask <= n_mask;
        r_hnd  <= n_hnd;
    end

    // Output register: load a finished result, drop it when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_mask  <= r_mask;
            r_out_ticks <= r_ticks;
            r_out_hnd   <= r_hnd;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_hnd, r_out_ticks, r_out_mask};

    // Checks
    `MCTT_ASSERT_NEXT(a_tick_only_advances, i_clk, i_rst_n,
        s_acc && t_req'(i_s_tuser) != REQ_TICK, $stable(r_ticks))
    `MCTT_ASSERT_SAME(a_mask_only_on_tick, i_clk, i_rst_n,
        r_state == S_DONE && r_req != REQ_TICK, r_mask == '0)
    `MCTT_ASSERT_SAME(a_sweep_no_overlap, i_clk, i_rst_n,
        r_state == S_SWEEP && ram_we && r_step < STEP_W'(NUM_TIMERS),
        ram_waddr != ram_raddr)

endmodule
